@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/mlc_pkg.sv @@
// ---------------------------------------------------------------------------
// Marker locator package
// Beat payloads, table entry layout, fixed-point constants and helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package mlc_pkg;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LOCATE = 1'b1;

   localparam int ATAN_ENTRIES = 24;
   localparam int TH_W  = 36;
   localparam int CS_W  = 34;
   localparam int MA_W  = 35;
   localparam int MB_W  = 34;
   localparam int ACC_W = 72;

   localparam logic signed [20:0]     PI_Q16      = 21'sd205887;
   localparam logic signed [TH_W-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [TH_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [TH_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [CS_W-1:0] GAIN_Q30    = 34'sd652032874;

   typedef struct packed {
      logic              cmd;
      logic [3:0]        slot;
      logic [9:0]        marker_id;
      logic [7:0]        markers_seen;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic signed [19:0] angle;
   } req_payload_type;

   typedef struct packed {
      logic [9:0]         found_id;
      logic signed [31:0] map_x;
      logic signed [31:0] map_y;
      logic signed [31:0] map_z;
   } rsp_payload_type;

   typedef struct packed {
      logic [9:0]         marker_id;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [19:0] yaw;
   } slot_entry_type;

   typedef struct packed {
      logic                  go;
      logic                  first;
      logic                  sub;
      logic signed [MA_W-1:0] a;
      logic signed [MB_W-1:0] b;
   } mac_op_type;

   function automatic logic signed [TH_W-1:0] atan_q30(input logic [4:0] idx);
      logic signed [TH_W-1:0] v;
      case (idx)
         5'd0:    v = 36'sh03243F6A8;
         5'd1:    v = 36'sh01DAC6705;
         5'd2:    v = 36'sh00FADBAFC;
         5'd3:    v = 36'sh007F56EA6;
         5'd4:    v = 36'sh003FEAB76;
         5'd5:    v = 36'sh001FFD55B;
         5'd6:    v = 36'sh000FFFAAA;
         5'd7:    v = 36'sh0007FFF55;
         5'd8:    v = 36'sh0003FFFEA;
         5'd9:    v = 36'sh0001FFFFD;
         5'd10:   v = 36'sh0000FFFFF;
         5'd11:   v = 36'sh00007FFFF;
         5'd12:   v = 36'sh00003FFFF;
         5'd13:   v = 36'sh00001FFFF;
         5'd14:   v = 36'sh00000FFFF;
         5'd15:   v = 36'sh000007FFF;
         5'd16:   v = 36'sh000003FFF;
         5'd17:   v = 36'sh000001FFF;
         5'd18:   v = 36'sh000000FFF;
         5'd19:   v = 36'sh0000007FF;
         5'd20:   v = 36'sh0000003FF;
         5'd21:   v = 36'sh0000001FF;
         5'd22:   v = 36'sh0000000FF;
         5'd23:   v = 36'sh00000007F;
         default: v = '0;
      endcase
      return v;
   endfunction

   // round half up from Q46 to Q16
   function automatic logic signed [41:0] rnd30(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] t;
      t = acc + (72'sd1 <<< 29);
      return t[ACC_W-1:30];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
      logic signed [31:0] r;
      if (v > 43'sd2147483647)
         r = 32'sh7FFFFFFF;
      else if (v < -43'sd2147483648)
         r = 32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

`default_nettype wire

@@ design/mlc_if.sv @@
// ---------------------------------------------------------------------------
// Marker locator channels
// Valid/ready channels for request and response beats.
// ---------------------------------------------------------------------------
`default_nettype none

interface mlc_req_if;
   logic                     valid;
   logic                     ready;
   mlc_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mlc_rsp_if;
   logic                     valid;
   logic                     ready;
   mlc_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/mlc_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module mlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [AW-1:0]        waddr,
   input  wire logic [WIDTH-1:0]     wdata,
   input  wire logic [AW-1:0]        raddr,
   output      logic [WIDTH-1:0]     rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

`default_nettype wire

@@ design/mlc_mac.sv @@
// ---------------------------------------------------------------------------
// Marker locator multiply-accumulate
// Registered product, then add or subtract into the accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

module mlc_mac (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire mlc_pkg::mac_op_type                 op,
   output      logic signed [mlc_pkg::ACC_W-1:0]    acc
);
   localparam int PW = mlc_pkg::MA_W + mlc_pkg::MB_W;

   logic signed [PW-1:0]              prod_ff;
   logic                              go_ff;
   logic                              first_ff;
   logic                              sub_ff;
   logic signed [mlc_pkg::ACC_W-1:0]  acc_ff;
   logic signed [mlc_pkg::ACC_W-1:0]  base;
   logic signed [mlc_pkg::ACC_W-1:0]  term;

   assign base = first_ff ? '0 : acc_ff;
   assign term = mlc_pkg::ACC_W'(prod_ff);
   assign acc  = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff <= 1'b0;
      end else begin
         go_ff <= op.go;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= PW'(op.a) * PW'(op.b);
      first_ff <= op.first;
      sub_ff   <= op.sub;
      if (go_ff) begin
         acc_ff <= sub_ff ? (base - term) : (base + term);
      end
   end
endmodule

`default_nettype wire

@@ design/mlc_cordic.sv @@
// ---------------------------------------------------------------------------
// Marker locator sine/cosine unit
// Milliradian rounding, range folding and iterative CORDIC rotation.
// ---------------------------------------------------------------------------
`default_nettype none

module mlc_cordic #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [19:0]                  angle,
   output      logic                                done,
   output      logic signed [mlc_pkg::CS_W-1:0]     cos_out,
   output      logic signed [mlc_pkg::CS_W-1:0]     sin_out
);
   localparam int IW = $clog2(CORDIC_STEPS);
   localparam int TW = mlc_pkg::TH_W;
   localparam int CW = mlc_pkg::CS_W;

   typedef enum logic [3:0] {
      C_IDLE, C_MRAD, C_MUL, C_QUO, C_SIGN, C_RED, C_FOLD, C_ITER, C_DONE
   } state_type;

   state_type          state_ff;
   logic               done_ff;
   logic               neg_ff;
   logic [19:0]        u_ff;
   logic [13:0]        mrad_ff;
   logic [34:0]        p1_ff;
   logic [19:0]        v_ff;
   logic [12:0]        q_ff;
   logic signed [TW-1:0] th_ff;
   logic               flip_ff;
   logic signed [CW-1:0] x_ff;
   logic signed [CW-1:0] y_ff;
   logic [IW-1:0]      i_ff;
   logic signed [CW-1:0] cos_ff;
   logic signed [CW-1:0] sin_ff;

   logic signed [20:0] a_wide;
   logic [19:0]        u_in;
   logic [29:0]        u30;
   logic [29:0]        scaled;
   logic [40:0]        qprod;
   logic [TW-1:0]      mag;
   logic signed [CW-1:0] dx;
   logic signed [CW-1:0] dy;
   logic signed [TW-1:0] at;

   assign a_wide = 21'(angle);
   assign u_in   = angle[19] ? 20'(-a_wide) : 20'(a_wide);
   assign u30    = 30'(u_ff);
   assign scaled = (u30 << 10) - (u30 << 4) - (u30 << 3) + 30'd32768;
   assign qprod  = 41'(v_ff) * 41'd1073742;
   assign mag    = TW'(p1_ff) + TW'(q_ff);
   assign dx     = y_ff >>> i_ff;
   assign dy     = x_ff >>> i_ff;
   assign at     = mlc_pkg::atan_q30(5'(i_ff));

   assign done    = done_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == C_DONE);
         case (state_ff)
            C_IDLE: begin
               if (start) begin
                  neg_ff   <= angle[19];
                  u_ff     <= u_in;
                  state_ff <= C_MRAD;
               end
            end
            C_MRAD: begin
               mrad_ff  <= scaled[29:16];
               state_ff <= C_MUL;
            end
            C_MUL: begin
               p1_ff    <= 35'(mrad_ff) * 35'd1073741;
               v_ff     <= 20'(mrad_ff) * 20'd103 + 20'd62;
               state_ff <= C_QUO;
            end
            C_QUO: begin
               q_ff     <= qprod[39:27];
               state_ff <= C_SIGN;
            end
            C_SIGN: begin
               th_ff    <= neg_ff ? -$signed(mag) : $signed(mag);
               state_ff <= C_RED;
            end
            C_RED: begin
               if (th_ff > mlc_pkg::PI_Q30) begin
                  th_ff <= th_ff - mlc_pkg::TWO_PI_Q30;
               end else if (th_ff < -mlc_pkg::PI_Q30) begin
                  th_ff <= th_ff + mlc_pkg::TWO_PI_Q30;
               end
               state_ff <= C_FOLD;
            end
            C_FOLD: begin
               if (th_ff > mlc_pkg::HALF_PI_Q30) begin
                  th_ff   <= th_ff - mlc_pkg::PI_Q30;
                  flip_ff <= 1'b1;
               end else if (th_ff < -mlc_pkg::HALF_PI_Q30) begin
                  th_ff   <= th_ff + mlc_pkg::PI_Q30;
                  flip_ff <= 1'b1;
               end else begin
                  flip_ff <= 1'b0;
               end
               x_ff     <= mlc_pkg::GAIN_Q30;
               y_ff     <= '0;
               i_ff     <= '0;
               state_ff <= C_ITER;
            end
            C_ITER: begin
               if (!th_ff[TW-1]) begin
                  x_ff  <= x_ff - dx;
                  y_ff  <= y_ff + dy;
                  th_ff <= th_ff - at;
               end else begin
                  x_ff  <= x_ff + dx;
                  y_ff  <= y_ff - dy;
                  th_ff <= th_ff + at;
               end
               if (i_ff == IW'(CORDIC_STEPS - 1)) begin
                  state_ff <= C_DONE;
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            C_DONE: begin
               cos_ff   <= flip_ff ? -x_ff : x_ff;
               sin_ff   <= flip_ff ? -y_ff : y_ff;
               state_ff <= C_IDLE;
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end
endmodule

`default_nettype wire

@@ design/marker_pose_to_map_locator_top.sv @@
// ---------------------------------------------------------------------------
// Marker pose to map locator
// Marker table plus camera pose transform into the map frame.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries load beats (cmd load: write one table slot) and locate
//   beats (cmd locate: detection). rsp_chan carries at most one beat per
//   locate: the matched id and the camera position in the map frame.
//   A load leaves the block idle; req_chan.ready stays high for the next beat.
//   A locate with no markers seen also leaves the block idle and gives no beat.
//   Otherwise the table is scanned one slot per cycle from the lowest slot
//   through a single registered RAM read port until a hit or the last slot.
//   A miss ends there with no beat. A hit runs the shared CORDIC unit twice
//   and the shared multiply-accumulate unit twice. One item is in work
//   at a time.
//   The result sits in an output register; while rsp_chan stalls, the block
//   holds it there and keeps taking request beats, and a later locate waits
//   in its last state until the register frees.
//   Synchronous reset empties the table (all slots invalid) and drops any
//   result in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module marker_pose_to_map_locator_top #(
   parameter int TABLE_SLOTS  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mlc_req_if.sink    req_chan,
   mlc_rsp_if.source  rsp_chan
);
   localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int EW = $bits(mlc_pkg::slot_entry_type);
   localparam int CW = mlc_pkg::CS_W;
   localparam logic [AW-1:0] LAST = AW'(TABLE_SLOTS - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SRCH, S_ROT, S_ROT_WAIT, S_MAC_A, S_YAW, S_YAW_WAIT, S_MAC_B, S_OUT
   } state_type;

   state_type                  state_ff;
   logic                       valid_ff [TABLE_SLOTS];
   logic [AW-1:0]              idx_ff;
   logic [AW-1:0]              cmp_idx_ff;
   logic                       cmp_v_ff;
   logic [2:0]                 cnt_ff;
   logic                       rsp_valid_ff;
   mlc_pkg::rsp_payload_type   rsp_payload_ff;

   mlc_pkg::req_payload_type   job_ff;
   logic signed [19:0]         rot_ff;
   mlc_pkg::slot_entry_type    ent_ff;
   logic signed [CW-1:0]       c_ff;
   logic signed [CW-1:0]       s_ff;
   logic signed [33:0]         mx_ff;
   logic signed [34:0]         mz_ff;
   logic signed [31:0]         x_ff;
   logic signed [31:0]         y_ff;
   logic signed [31:0]         z_ff;

   logic                       accept;
   logic                       load_we;
   logic [EW-1:0]              ram_rdata;
   mlc_pkg::slot_entry_type    rd_ent;
   mlc_pkg::slot_entry_type    wr_ent;
   logic                       hit;
   logic signed [20:0]         rot_in;
   logic                       cor_start;
   logic signed [19:0]         cor_angle;
   logic                       cor_done;
   logic signed [CW-1:0]       cor_cos;
   logic signed [CW-1:0]       cor_sin;
   mlc_pkg::mac_op_type        mac_op;
   logic signed [mlc_pkg::ACC_W-1:0] acc;
   logic signed [41:0]         acc_rnd;
   logic signed [33:0]         mz_raw;

   assign accept  = req_chan.valid && req_chan.ready;
   assign load_we = accept && (req_chan.payload.cmd == mlc_pkg::CMD_LOAD)
                    && (9'(req_chan.payload.slot) < 9'(TABLE_SLOTS));

   assign wr_ent.marker_id = req_chan.payload.marker_id;
   assign wr_ent.pos_x     = req_chan.payload.vec_x;
   assign wr_ent.pos_y     = req_chan.payload.vec_y;
   assign wr_ent.pos_z     = req_chan.payload.vec_z;
   assign wr_ent.yaw       = req_chan.payload.angle;

   mlc_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_SLOTS)
   ) u_table (
      .clock (clock),
      .we    (load_we),
      .waddr (AW'(req_chan.payload.slot)),
      .wdata (wr_ent),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   assign rd_ent = mlc_pkg::slot_entry_type'(ram_rdata);
   assign hit    = cmp_v_ff && valid_ff[cmp_idx_ff] && (rd_ent.marker_id == job_ff.marker_id);
   assign rot_in = mlc_pkg::PI_Q16 - 21'(req_chan.payload.angle);

   assign cor_start = (state_ff == S_ROT) || (state_ff == S_YAW);
   assign cor_angle = (state_ff == S_ROT) ? rot_ff : ent_ff.yaw;

   mlc_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .done    (cor_done),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   always_comb begin
      mac_op.go    = ((state_ff == S_MAC_A) || (state_ff == S_MAC_B)) && !cnt_ff[2];
      mac_op.first = !cnt_ff[0];
      mac_op.sub   = 1'b0;
      mac_op.a     = '0;
      mac_op.b     = '0;
      if (state_ff == S_MAC_A) begin
         case (cnt_ff[1:0])
            2'd0: begin
               mac_op.a = 35'(job_ff.vec_x); mac_op.b = c_ff; mac_op.sub = 1'b1;
            end
            2'd1: begin
               mac_op.a = 35'(job_ff.vec_z); mac_op.b = s_ff; mac_op.sub = 1'b1;
            end
            2'd2: begin
               mac_op.a = 35'(job_ff.vec_z); mac_op.b = c_ff; mac_op.sub = 1'b1;
            end
            default: begin
               mac_op.a = 35'(job_ff.vec_x); mac_op.b = s_ff;
            end
         endcase
      end else begin
         case (cnt_ff[1:0])
            2'd0: begin
               mac_op.a = 35'(mx_ff); mac_op.b = c_ff;
            end
            2'd1: begin
               mac_op.a = mz_ff; mac_op.b = s_ff; mac_op.sub = 1'b1;
            end
            2'd2: begin
               mac_op.a = 35'(mx_ff); mac_op.b = s_ff;
            end
            default: begin
               mac_op.a = mz_ff; mac_op.b = c_ff;
            end
         endcase
      end
   end

   mlc_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op    (mac_op),
      .acc   (acc)
   );

   assign acc_rnd = mlc_pkg::rnd30(acc);
   assign mz_raw  = acc_rnd[33:0];

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cmp_v_ff     <= 1'b0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (rsp_chan.ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               idx_ff   <= '0;
               cmp_v_ff <= 1'b0;
               if (load_we) begin
                  valid_ff[AW'(req_chan.payload.slot)] <= 1'b1;
               end
               if (accept && (req_chan.payload.cmd == mlc_pkg::CMD_LOCATE)
                   && (req_chan.payload.markers_seen != 8'd0)) begin
                  state_ff <= S_SRCH;
               end
            end
            S_SRCH: begin
               cmp_v_ff <= 1'b1;
               if (idx_ff != LAST) begin
                  idx_ff <= idx_ff + 1'b1;
               end
               if (hit) begin
                  state_ff <= S_ROT;
               end else if (cmp_v_ff && (cmp_idx_ff == LAST)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_ROT: state_ff <= S_ROT_WAIT;
            S_ROT_WAIT: begin
               cnt_ff <= '0;
               if (cor_done) begin
                  state_ff <= S_MAC_A;
               end
            end
            S_MAC_A: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 3'd5) begin
                  state_ff <= S_YAW;
               end
            end
            S_YAW: state_ff <= S_YAW_WAIT;
            S_YAW_WAIT: begin
               cnt_ff <= '0;
               if (cor_done) begin
                  state_ff <= S_MAC_B;
               end
            end
            S_MAC_B: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 3'd5) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= idx_ff;
      if (accept) begin
         job_ff <= req_chan.payload;
         rot_ff <= (req_chan.payload.angle > 20'sd0) ? rot_in[19:0] : req_chan.payload.angle;
      end
      if ((state_ff == S_SRCH) && hit) begin
         ent_ff <= rd_ent;
      end
      if (cor_done) begin
         c_ff <= cor_cos;
         s_ff <= cor_sin;
      end
      if ((state_ff == S_MAC_A) && (cnt_ff == 3'd3)) begin
         mx_ff <= mz_raw;
      end
      if ((state_ff == S_MAC_A) && (cnt_ff == 3'd5)) begin
         mz_ff <= mz_raw[33] ? -35'(mz_raw) : 35'(mz_raw);
      end
      if ((state_ff == S_MAC_B) && (cnt_ff == 3'd3)) begin
         x_ff <= mlc_pkg::sat32(43'(acc_rnd) + 43'(ent_ff.pos_x));
         y_ff <= mlc_pkg::sat32(43'(ent_ff.pos_y) - 43'(job_ff.vec_y));
      end
      if ((state_ff == S_MAC_B) && (cnt_ff == 3'd5)) begin
         z_ff <= mlc_pkg::sat32(43'(acc_rnd) + 43'(ent_ff.pos_z));
      end
      if ((state_ff == S_OUT) && (!rsp_valid_ff || rsp_chan.ready)) begin
         rsp_payload_ff.found_id <= job_ff.marker_id;
         rsp_payload_ff.map_x    <= x_ff;
         rsp_payload_ff.map_y    <= y_ff;
         rsp_payload_ff.map_z    <= z_ff;
      end
   end
endmodule

`default_nettype wire

@@ design/mlc_checker.sv @@
// ---------------------------------------------------------------------------
// Marker locator port checker
// Port-level checks of the handshakes and of how request beats end.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mlc_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     req_cmd,
   input wire logic [7:0]               req_seen,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire mlc_pkg::rsp_payload_type rsp_payload
);
   logic req_fire;
   logic req_quick;
   logic req_long;

   assign req_fire  = req_valid && req_ready;
   assign req_quick = req_fire && ((req_cmd == mlc_pkg::CMD_LOAD) || (req_seen == 8'd0));
   assign req_long  = req_fire && (req_cmd == mlc_pkg::CMD_LOCATE) && (req_seen != 8'd0);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp beat dropped")
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload), "rsp payload moved")
   `ASSERT_NEXT(a_quick_done, clock, reset, req_quick, req_ready, "short beat kept block busy")
   `ASSERT_NEXT(a_long_busy, clock, reset, req_long, !req_ready, "locate beat not started")
   `ASSERT_NEXT(a_no_rsp_load, clock, reset, req_quick, !$rose(rsp_valid), "rsp without locate")
endmodule

bind marker_pose_to_map_locator_top mlc_checker u_mlc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_cmd     (req_chan.payload.cmd),
   .req_seen    (req_chan.payload.markers_seen),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

`default_nettype wire
